// File: rtl/mrt_pkg.sv
// Package for the mapped region table: sizes, command and status codes,
// and the request, result and entry types. No dependencies.
package mrt_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BITS  = 12;
  localparam int AW         = 38;
  localparam int SLOT_W     = 4;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [AW-1:0] BASE_RESET = 38'h0040000000;
  localparam logic [AW-1:0] TOP_RESET  = 38'h3FFFFFE000;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_FAULT = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADARG  = 3'd1,
    ST_BOUNDS  = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_FULL    = 3'd4,
    ST_NOMAP   = 3'd5,
    ST_WDENY   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_BASE = 2'd0,
    CFG_TOP  = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [AW-1:0]      address;
    logic signed [31:0] region_length;
    logic               want_read;
    logic               want_write;
    logic               anonymous;
    logic signed [31:0] file_offset_in;
    logic               is_read;
  } req_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [3:0]    slot;
    logic [AW-1:0] mapped_address;
    logic [AW-1:0] page_address;
    logic [31:0]   page_file_offset;
    logic          page_readable;
    logic          page_writable;
    logic          page_anonymous;
  } rsp_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [30:0]   length;
    logic [30:0]   offset;
    logic          writable;
    logic          anonymous;
  } entry_t;

  // Control from the sequencer into the cell row.
  typedef struct packed {
    logic        shift;
    logic        do_write;
    logic        do_clear;
    logic        tag_free;
    logic [IDX_W-1:0] sel;
    entry_t      wdata;
  } row_ctl_t;

endpackage

// File: rtl/mrt_if.sv
// Valid/ready channel interface carrying a payload of any type.
// Depends on nothing; payload types come from mrt_pkg.
interface mrt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mrt_cell.sv
// One table slot: holds an entry and passes a circulating copy to its
// neighbor. Depends on mrt_pkg.
module mrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  logic              wr,
  input  logic              clr,
  input  mrt_pkg::entry_t   wdata,
  input  mrt_pkg::entry_t   prev,
  output mrt_pkg::entry_t   cur
);
  import mrt_pkg::*;

  entry_t ent_r, ent_nxt;

  // Rotate on scan, else take a write or a clear at this slot.
  always_comb begin
    ent_nxt = ent_r;
    if (shift)    ent_nxt = prev;
    else if (clr) ent_nxt = '0;
    else if (wr)  ent_nxt = wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ent_r <= '0;
    else        ent_r <= ent_nxt;
  end

  assign cur = ent_r;
endmodule

// File: rtl/mrt_row.sv
// Ring of slot cells. A full rotation of ENTRIES shifts presents each
// entry at the head in order and leaves the table where it started.
// Depends on mrt_pkg and mrt_cell.
module mrt_row (
  input  logic              clk,
  input  logic              rst_n,
  input  mrt_pkg::row_ctl_t ctl,
  output mrt_pkg::entry_t   head
);
  import mrt_pkg::*;

  entry_t ring [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    mrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ctl.shift),
      .wr    (ctl.do_write && ctl.sel == IDX_W'(g)),
      .clr   (ctl.do_clear && ctl.sel == IDX_W'(g)),
      .wdata (ctl.wdata),
      .prev  (ring[(g + 1) % ENTRIES]),
      .cur   (ring[g])
    );
  end

  assign head = ring[0];
endmodule

// File: rtl/mapped_region_table_top.sv
// Mapped region table top level: handshakes, argument checks, scan
// sequencer and result register. Depends on mrt_pkg, mrt_if, mrt_row.
//
// Usage: requests enter on in_ (command, address, length, protection,
// file offset, access kind). Each request gives exactly one result on
// out_. Registers region_base (index 0) and region_top (index 1) are
// written on the cfg_ channel; the user must do so only while the block is
// idle, since the block itself does not enforce it.
// Processing: the request is latched, the slot ring then rotates once
// past the comparators, and the result is posted to the output register.
// One request is handled at a time; a new request is taken only once the
// last has left the final step.
// The result waits in an output register. The next request is accepted
// and scanned while it waits; its own result holds in the final step
// until out_ready frees the register.
// Reset: all slots become free, region_base and region_top take their
// reset values and both channels come up empty.
module mapped_region_table_top (
  input  logic               clk,
  input  logic               rst_n,
  mrt_if.sink                in_ch,
  mrt_if.source              out_ch,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [37:0]        cfg_data
);
  import mrt_pkg::*;

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [AW-1:0] base_r, top_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] pos_r;
  logic           pre_ok_r;
  logic [2:0]     pre_st_r;
  logic [AW-1:0]  vs_r, ve_r;
  logic           ovl_r, free_f_r, hit_r;
  logic [IDX_W-1:0] free_r, hit_idx_r;
  entry_t         hit_e_r;
  rsp_t           rsp_r, rsp_nxt;
  logic           out_v_r;
  logic           done_go;
  row_ctl_t       ctl;
  entry_t         head;

  // The final step completes once the output register is free.
  assign done_go = (state_r == S_DONE) && (!out_v_r || out_ch.ready);

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      top_r  <= TOP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(CFG_BASE)) base_r <= cfg_data;
      else                           top_r  <= cfg_data;
    end
  end

  // Argument checks for map, unmap and invalid commands, evaluated on the incoming request.
  logic [31:0]   lraw;
  logic [AW:0]   vs_w;
  logic [AW+1:0] ve_w;
  logic [2:0]    pre_st_w;
  logic          pre_ok_w;
  always_comb begin
    lraw = in_ch.data.region_length;
    vs_w = {1'b0, base_r} + {1'b0, in_ch.data.address};
    ve_w = {1'b0, vs_w} + (AW+2)'(lraw);
    pre_ok_w = 1'b1;
    pre_st_w = ST_OK;
    unique case (in_ch.data.command)
      CMD_MAP: begin
        if (lraw == 32'd0 || lraw[31] || in_ch.data.address[PAGE_BITS-1:0] != '0 ||
            lraw[PAGE_BITS-1:0] != '0 || !in_ch.data.want_read) begin
          pre_ok_w = 1'b0; pre_st_w = ST_BADARG;
        end else if (ve_w > {2'b00, top_r}) begin
          pre_ok_w = 1'b0; pre_st_w = ST_BOUNDS;
        end else if (!in_ch.data.anonymous && in_ch.data.file_offset_in[31]) begin
          pre_ok_w = 1'b0; pre_st_w = ST_BADARG;
        end
      end
      CMD_UNMAP: begin
        if (in_ch.data.address[PAGE_BITS-1:0] != '0) begin
          pre_ok_w = 1'b0; pre_st_w = ST_BADARG;
        end
      end
      CMD_FAULT: ;
      default: begin
        pre_ok_w = 1'b0; pre_st_w = ST_BADARG;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_SCAN;
      S_SCAN: if (cnt_r == CNT_W'(ENTRIES - 1)) state_nxt = S_DONE;
      S_DONE: if (done_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Head-of-ring comparisons during the scan.
  logic [AW:0] hs_end;
  logic        head_used, ovl_now, cover_now, match_now;
  always_comb begin
    head_used = head.length != '0;
    hs_end    = {1'b0, head.start} + (AW+1)'(head.length);
    ovl_now   = head_used && !({1'b0, ve_r} <= {1'b0, head.start} ||
                               hs_end <= {1'b0, vs_r});
    cover_now = head_used && head.start <= req_r.address &&
                {1'b0, req_r.address} < hs_end;
    match_now = head_used && head.start == req_r.address;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
        pos_r <= pos_r + 1'b1;
      end else begin
        cnt_r <= '0;
        pos_r <= '0;
      end
    end
  end

  // Request capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      req_r    <= in_ch.data;
      pre_ok_r <= pre_ok_w;
      pre_st_r <= pre_st_w;
      vs_r     <= vs_w[AW-1:0];
      ve_r     <= ve_w[AW-1:0];
      ovl_r    <= ve_w[AW];
      free_f_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= '0;
      hit_idx_r <= '0;
      hit_e_r  <= '0;
    end else if (state_r == S_SCAN) begin
      if (ovl_now) ovl_r <= 1'b1;
      if (!head_used && !free_f_r) begin
        free_f_r <= 1'b1;
        free_r   <= pos_r;
      end
      if (!hit_r && ((req_r.command == CMD_FAULT && cover_now) ||
                     (req_r.command == CMD_UNMAP && match_now))) begin
        hit_r     <= 1'b1;
        hit_idx_r <= pos_r;
        hit_e_r   <= head;
      end
    end
  end

  // Result and table update formed at the end of the scan.
  logic [AW-1:0] page;
  logic [AW:0]   he_end;
  always_comb begin
    page   = {req_r.address[AW-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
    he_end = {1'b0, hit_e_r.start} + (AW+1)'(hit_e_r.length);
    rsp_nxt = '0;
    ctl = '0;
    ctl.shift = (state_r == S_SCAN);
    ctl.sel   = (req_r.command == CMD_MAP) ? free_r : hit_idx_r;
    ctl.wdata.start     = vs_r;
    ctl.wdata.length    = req_r.region_length[30:0];
    ctl.wdata.offset    = req_r.anonymous ? 31'd0 : req_r.file_offset_in[30:0];
    ctl.wdata.writable  = req_r.want_write;
    ctl.wdata.anonymous = req_r.anonymous;
    if (!pre_ok_r) begin
      rsp_nxt.status = pre_st_r;
    end else begin
      case (req_r.command)
        CMD_MAP: begin
          if (ovl_r) rsp_nxt.status = ST_OVERLAP;
          else if (!free_f_r) rsp_nxt.status = ST_FULL;
          else begin
            rsp_nxt.status = ST_OK;
            rsp_nxt.slot = SLOT_W'(free_r);
            rsp_nxt.mapped_address = vs_r;
            ctl.do_write = done_go;
          end
        end
        CMD_UNMAP: begin
          if (!hit_r) rsp_nxt.status = ST_NOMAP;
          else begin
            rsp_nxt.status = ST_OK;
            rsp_nxt.slot = SLOT_W'(hit_idx_r);
            ctl.do_clear = done_go;
          end
        end
        default: begin
          if (!hit_r) rsp_nxt.status = ST_NOMAP;
          else begin
            rsp_nxt.slot = SLOT_W'(hit_idx_r);
            if (!req_r.is_read && !hit_e_r.writable) rsp_nxt.status = ST_WDENY;
            else if (page < hit_e_r.start || {1'b0, page} >= he_end)
              rsp_nxt.status = ST_NOMAP;
            else begin
              rsp_nxt.status = ST_OK;
              rsp_nxt.page_address = page;
              if (!hit_e_r.anonymous)
                rsp_nxt.page_file_offset = 32'(hit_e_r.offset) +
                                           32'(page - hit_e_r.start);
              rsp_nxt.page_readable  = 1'b1;
              rsp_nxt.page_writable  = hit_e_r.writable;
              rsp_nxt.page_anonymous = hit_e_r.anonymous;
            end
          end
        end
      endcase
    end
  end

  mrt_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (done_go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) rsp_r <= rsp_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = rsp_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("request taken while busy");
  a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_ch.valid) else $error("result not posted");
  a_one_edit: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.do_write && ctl.do_clear)) else $error("write and clear together");
`endif
endmodule

// File: bench/tb_top.sv
// Testbench for mapped_region_table_top: drives map, unmap and fault requests
// and checks every result against an in-bench model of the region table.
// Depends on mrt_pkg, mrt_if and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import mrt_pkg::*;

  // Region table model and queue of results still owed by the block.
  class region_table_sb;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] top_reg;
    logic [AW-1:0] slot_start [ENTRIES];
    logic [30:0]   slot_len   [ENTRIES];
    logic [30:0]   slot_off   [ENTRIES];
    logic          slot_wr    [ENTRIES];
    logic          slot_anon  [ENTRIES];
    rsp_t          owed_q[$];
    int            mismatches;

    function new();
      base_reg = BASE_RESET;
      top_reg  = TOP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_start[i] = '0;
        slot_len[i]   = '0;
        slot_off[i]   = '0;
        slot_wr[i]    = 1'b0;
        slot_anon[i]  = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [AW-1:0] val);
      if (idx == CFG_BASE) base_reg = val;
      else top_reg = val;
    endfunction

    function status_t map_region(req_t r, ref rsp_t o);
      bit [31:0] lraw;
      bit [63:0] len;
      bit [63:0] vs;
      bit [63:0] ve;
      int        free_slot;
      lraw = r.region_length;
      free_slot = -1;
      if (lraw == 0 || lraw[31]) return ST_BADARG;
      len = lraw;
      if (r.address[PAGE_BITS-1:0] != 0 || len[PAGE_BITS-1:0] != 0 || !r.want_read)
        return ST_BADARG;
      vs = 64'(base_reg) + 64'(r.address);
      ve = vs + len;
      if (ve > 64'(top_reg)) return ST_BOUNDS;
      if (!r.anonymous && r.file_offset_in[31]) return ST_BADARG;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_len[i] != 0 &&
            !(ve <= 64'(slot_start[i]) || 64'(slot_start[i]) + 64'(slot_len[i]) <= vs))
          return ST_OVERLAP;
      end
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (slot_len[i] == 0) free_slot = i;
      if (free_slot < 0) return ST_FULL;
      slot_start[free_slot] = vs[AW-1:0];
      slot_len[free_slot]   = len[30:0];
      slot_off[free_slot]   = r.anonymous ? 31'd0 : r.file_offset_in[30:0];
      slot_wr[free_slot]    = r.want_write;
      slot_anon[free_slot]  = r.anonymous;
      o.slot = 4'(free_slot);
      o.mapped_address = vs[AW-1:0];
      return ST_OK;
    endfunction

    function status_t unmap_region(req_t r, ref rsp_t o);
      if (r.address[PAGE_BITS-1:0] != 0) return ST_BADARG;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_len[i] != 0 && slot_start[i] == r.address) begin
          slot_start[i] = '0;
          slot_len[i]   = '0;
          slot_off[i]   = '0;
          slot_wr[i]    = 1'b0;
          slot_anon[i]  = 1'b0;
          o.slot = 4'(i);
          return ST_OK;
        end
      end
      return ST_NOMAP;
    endfunction

    function status_t fault_lookup(req_t r, ref rsp_t o);
      bit [63:0] va;
      bit [63:0] pg;
      bit [63:0] s;
      bit [63:0] e;
      int        hit;
      va = r.address;
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (slot_len[i] != 0 && 64'(slot_start[i]) <= va &&
            va < 64'(slot_start[i]) + 64'(slot_len[i]))
          hit = i;
      if (hit < 0) return ST_NOMAP;
      o.slot = 4'(hit);
      if (!r.is_read && !slot_wr[hit]) return ST_WDENY;
      pg = va & ~((64'd1 << PAGE_BITS) - 1);
      s = slot_start[hit];
      e = s + slot_len[hit];
      // A base that is not page aligned can round the page below the start.
      if (pg < s || pg >= e) return ST_NOMAP;
      o.page_address = pg[AW-1:0];
      if (!slot_anon[hit]) o.page_file_offset = 32'(64'(slot_off[hit]) + (pg - s));
      o.page_readable  = 1'b1;
      o.page_writable  = slot_wr[hit];
      o.page_anonymous = slot_anon[hit];
      return ST_OK;
    endfunction

    // Work out the result of an accepted request and queue it.
    function void note_request(req_t r);
      rsp_t    o;
      status_t st;
      logic [3:0] keep;
      o = '0;
      case (r.command)
        CMD_MAP:   st = map_region(r, o);
        CMD_UNMAP: st = unmap_region(r, o);
        CMD_FAULT: st = fault_lookup(r, o);
        default:   st = ST_BADARG;
      endcase
      if (st != ST_OK) begin
        keep = (st == ST_WDENY || (st == ST_NOMAP && r.command == CMD_FAULT)) ? o.slot : 4'd0;
        o = '0;
        o.slot = keep;
      end
      o.status = st;
      owed_q.push_back(o);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.mapped_address !== want.mapped_address ||
          got.page_address !== want.page_address ||
          got.page_file_offset !== want.page_file_offset ||
          got.page_readable !== want.page_readable ||
          got.page_writable !== want.page_writable ||
          got.page_anonymous !== want.page_anonymous) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [0:0]    cfg_index;
  logic [37:0]   cfg_data;
  logic          calm;
  int            stall_left;

  mrt_if #(.T(req_t)) in_if ();
  mrt_if #(.T(rsp_t)) out_if ();

  region_table_sb sb;

  mapped_region_table_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, none once the run turns calm.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    if (calm || !rst_n) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Send one request, optionally after an idle gap.
  task automatic send_request(req_t r);
    int gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= r;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [AW-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t blank_req(cmd_t c, logic [AW-1:0] a);
    req_t r;
    r = '0;
    r.command = c;
    r.address = a;
    r.want_read = 1'b1;
    r.is_read = 1'b1;
    return r;
  endfunction

  function automatic req_t map_req(logic [AW-1:0] a, int pages, logic wr, logic anon,
                                   logic [31:0] off);
    req_t r;
    r = blank_req(CMD_MAP, a);
    r.region_length = 32'(pages) << PAGE_BITS;
    r.want_write = wr;
    r.anonymous = anon;
    r.file_offset_in = off;
    return r;
  endfunction

  // Random request: mostly well formed around the live table, some noise.
  function automatic req_t random_req();
    req_t r;
    int   k;
    int   s;
    k = $urandom_range(0, 99);
    if (k < 12) begin
      r.command        = 2'($urandom);
      r.address        = {6'($urandom), 32'($urandom)};
      r.region_length  = $urandom;
      r.want_read      = 1'($urandom);
      r.want_write     = 1'($urandom);
      r.anonymous      = 1'($urandom);
      r.file_offset_in = $urandom;
      r.is_read        = 1'($urandom);
      return r;
    end
    s = $urandom_range(0, ENTRIES - 1);
    if (k < 50) begin
      r = map_req(AW'($urandom_range(0, 63)) << PAGE_BITS, $urandom_range(1, 6),
                  1'($urandom), 1'($urandom), {1'b0, 31'($urandom)});
    end else if (k < 72) begin
      if ($urandom_range(0, 3) != 0) r = blank_req(CMD_UNMAP, sb.slot_start[s]);
      else r = blank_req(CMD_UNMAP,
                         sb.base_reg + (AW'($urandom_range(0, 63)) << PAGE_BITS));
    end else begin
      r = blank_req(CMD_FAULT, sb.slot_start[s] + AW'($urandom_range(0, 6 << PAGE_BITS)));
      r.is_read = 1'($urandom);
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_request(random_req());
  endtask

  initial begin
    req_t r;
    sb = new();
    rst_n = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: argument errors, overlap, lookups, removal and a full table.
    send_request(map_req('0, 2, 1'b1, 1'b0, 32'h7FFF_F000));
    send_request(map_req(AW'(1) << PAGE_BITS, 1, 1'b0, 1'b1, '0));
    send_request(map_req(AW'(8) << PAGE_BITS, 1, 1'b0, 1'b1, 32'h8000_0000));
    send_request(map_req(AW'(9) << PAGE_BITS, 0, 1'b0, 1'b1, '0));
    r = map_req(AW'(9) << PAGE_BITS, 1, 1'b0, 1'b0, '0);
    r.region_length = 32'sh8000_0000;
    send_request(r);
    r.region_length = 32'sh7FFF_FFFF;
    send_request(r);
    send_request(map_req(AW'(9) << PAGE_BITS | 1, 1, 1'b0, 1'b0, '0));
    r = map_req(AW'(9) << PAGE_BITS, 1, 1'b1, 1'b0, '0);
    r.want_read = 1'b0;
    send_request(r);
    send_request(map_req(AW'(9) << PAGE_BITS, 1, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_request(map_req({AW{1'b1}} << PAGE_BITS, 1, 1'b1, 1'b0, '0));
    send_request(map_req(AW'(10) << PAGE_BITS, 1, 1'b0, 1'b0, 32'h0000_0123));
    r = blank_req(CMD_FAULT, BASE_RESET + 38'h1FFF);
    send_request(r);
    r.is_read = 1'b0;
    send_request(r);
    r.address = BASE_RESET + (AW'(10) << PAGE_BITS) + 38'h7;
    send_request(r);
    r.address = BASE_RESET + (AW'(3) << PAGE_BITS);
    send_request(r);
    r.address = '1;
    send_request(r);
    send_request(blank_req(CMD_UNMAP, BASE_RESET + 38'h10));
    send_request(blank_req(CMD_UNMAP, BASE_RESET + (AW'(5) << PAGE_BITS)));
    send_request(blank_req(CMD_UNMAP, BASE_RESET));
    send_request(blank_req(CMD_BAD, BASE_RESET));
    for (int i = 0; i < ENTRIES; i++)
      send_request(map_req(AW'(32 + i) << PAGE_BITS, 1, 1'b1, 1'b1, '0));

    // Hold off until the table has answered everything, then go random.
    drain();
    random_phase(250);
    write_reg(CFG_BASE, '0);
    write_reg(CFG_TOP, '1);
    random_phase(250);
    write_reg(CFG_BASE, 38'h3F_0000_0000);
    write_reg(CFG_TOP, 38'h3F_0004_0000);
    random_phase(150);
    write_reg(CFG_BASE, 38'h3F_FFFF_F000);
    random_phase(100);
    write_reg(CFG_BASE, 38'h00_0000_0801);
    write_reg(CFG_TOP, TOP_RESET);
    random_phase(220);
    calm = 1'b1;
    random_phase(150);

    drain();
    if (sb.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
